### rtl/gdo_pkg.sv
// gdo_pkg: shared constants, command and status types, calendar helpers
`timescale 1ns / 1ps
`default_nettype none
package gdo_pkg;

  localparam int BASE_YEAR   = 1900;
  localparam int MAX_YEAR    = 9999;
  localparam int OFFSET_BITS = 16;
  localparam int MAG_BITS    = OFFSET_BITS + 1;

  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int YEAR_W   = 14;
  localparam int STATUS_W = 2;
  localparam int RED_W    = 3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOW     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HIGH    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  localparam logic [RED_W-1:0] RED_LAST = 3'd5;

  typedef struct packed {
    logic             load;
    logic             reduce;
    logic [RED_W-1:0] red_idx;
    logic             set_invalid;
    logic             sat_low;
    logic             sat_high;
    logic             step;
    logic             out_load;
  } gdo_cmd_t;

  typedef struct packed {
    logic date_ok;
    logic done;
    logic backward;
    logic at_low;
    logic at_high;
  } gdo_stat_t;

  // multiples of 400 used to reduce the year, largest first
  function automatic logic [YEAR_W-1:0] red_step(input logic [RED_W-1:0] idx);
    logic [YEAR_W-1:0] v;
    case (idx)
      3'd0:    v = 14'd12800;
      3'd1:    v = 14'd6400;
      3'd2:    v = 14'd3200;
      3'd3:    v = 14'd1600;
      3'd4:    v = 14'd800;
      default: v = 14'd400;
    endcase
    return v;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] v;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
      4'd2:                    v = leap ? 5'd29 : 5'd28;
      default:                 v = 5'd31;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/gdo_ctrl.sv
// gdo_ctrl: sequencer for load, year reduction, check, day stepping, result hand-off
`timescale 1ns / 1ps
`default_nettype none
module gdo_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire gdo_pkg::gdo_stat_t stat,
  output gdo_pkg::gdo_cmd_t      cmd
);
  import gdo_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]       state, state_next;
  logic [RED_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.red_idx    = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == RED_LAST) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.date_ok) begin
          cmd.set_invalid = 1'b1;
          state_next      = S_FINISH;
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.done) begin
          state_next = S_FINISH;
        end else if (!stat.backward && stat.at_high) begin
          cmd.sat_high = 1'b1;
          state_next   = S_FINISH;
        end else if (stat.backward && stat.at_low) begin
          cmd.sat_low = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        // wait until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE) && in_valid)
    else $error("item loaded outside idle");
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
  a_reduce_to_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_REDUCE) && (cnt == RED_LAST) |=> (state == S_CHECK))
    else $error("year reduction did not end in check");
`endif

endmodule
`default_nettype wire

### rtl/gdo_datapath.sv
// gdo_datapath: date registers, year residue, day counter and result registers
`timescale 1ns / 1ps
`default_nettype none
module gdo_datapath (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire gdo_pkg::gdo_cmd_t                       cmd,
  output gdo_pkg::gdo_stat_t                           stat,
  input  wire logic [gdo_pkg::MONTH_W-1:0]             start_month,
  input  wire logic [gdo_pkg::DAY_W-1:0]               start_day,
  input  wire logic [gdo_pkg::YEAR_W-1:0]              start_year,
  input  wire logic signed [gdo_pkg::OFFSET_BITS-1:0]  day_offset,
  output logic [gdo_pkg::MONTH_W-1:0]                  result_month,
  output logic [gdo_pkg::DAY_W-1:0]                    result_day,
  output logic [gdo_pkg::YEAR_W-1:0]                   result_year,
  output logic [gdo_pkg::STATUS_W-1:0]                 clamp_status
);
  import gdo_pkg::*;

  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [YEAR_W-1:0]   year;
  logic [YEAR_W-1:0]   r400;
  logic                backward;
  logic [MAG_BITS-1:0] remaining;
  logic [STATUS_W-1:0] status;

  logic [MAG_BITS-1:0] off_ext;
  logic [MAG_BITS-1:0] mag;
  logic [YEAR_W-1:0]   red_val;
  logic                leap;
  logic [DAY_W-1:0]    cur_len;
  logic [DAY_W-1:0]    prev_len;

  assign off_ext = {day_offset[OFFSET_BITS-1], day_offset};
  assign mag     = day_offset[OFFSET_BITS-1] ? (~off_ext + 1'b1) : off_ext;
  assign red_val = red_step(cmd.red_idx);

  // r400 holds year mod 400 once reduction is over
  assign leap = (r400 == '0) ||
                ((year[1:0] == 2'b00) && (r400 != 14'd100) && (r400 != 14'd200) &&
                 (r400 != 14'd300));
  assign cur_len  = month_len(month, leap);
  assign prev_len = month_len(month - 1'b1, leap);

  assign stat.date_ok  = (month >= 4'd1) && (month <= 4'd12) &&
                         (year >= YEAR_W'(BASE_YEAR)) && (year <= YEAR_W'(MAX_YEAR)) &&
                         (day >= 5'd1) && (day <= cur_len);
  assign stat.done     = (remaining == '0);
  assign stat.backward = backward;
  assign stat.at_low   = (month == 4'd1) && (day == 5'd1) && (year == YEAR_W'(BASE_YEAR));
  assign stat.at_high  = (month == 4'd12) && (day == 5'd31) && (year == YEAR_W'(MAX_YEAR));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      month     <= start_month;
      day       <= start_day;
      year      <= start_year;
      r400      <= start_year;
      backward  <= day_offset[OFFSET_BITS-1];
      remaining <= mag;
      status    <= ST_OK;
    end
    if (cmd.reduce && (r400 >= red_val)) r400 <= r400 - red_val;
    if (cmd.set_invalid) status <= ST_INVALID;
    if (cmd.sat_high)    status <= ST_HIGH;
    if (cmd.sat_low)     status <= ST_LOW;
    if (cmd.step) begin
      remaining <= remaining - 1'b1;
      if (!backward) begin
        if (day == cur_len) begin
          day <= 5'd1;
          if (month == 4'd12) begin
            month <= 4'd1;
            year  <= year + 1'b1;
            r400  <= (r400 == 14'd399) ? '0 : r400 + 1'b1;
          end else begin
            month <= month + 1'b1;
          end
        end else begin
          day <= day + 1'b1;
        end
      end else begin
        if (day == 5'd1) begin
          if (month == 4'd1) begin
            month <= 4'd12;
            day   <= 5'd31;
            year  <= year - 1'b1;
            r400  <= (r400 == '0) ? 14'd399 : r400 - 1'b1;
          end else begin
            month <= month - 1'b1;
            day   <= prev_len;
          end
        end else begin
          day <= day - 1'b1;
        end
      end
    end
    if (cmd.out_load) begin
      result_month <= month;
      result_day   <= day;
      result_year  <= year;
      clamp_status <= status;
    end
  end

`ifndef SYNTHESIS
  a_step_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (remaining == $past(remaining) - 1'b1))
    else $error("day counter did not advance");
  a_residue_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (r400 < 14'd400))
    else $error("year residue out of range while stepping");
  a_no_step_past_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !(backward ? stat.at_low : stat.at_high))
    else $error("stepped past a date limit");
`endif

endmodule
`default_nettype wire

### rtl/gregorian_date_offset.sv
// gregorian_date_offset: top level, adds a signed day count to a Gregorian date
// the day-stepping loop advances the date one day per cycle, up to 32768 steps
// throughput: one item at a time; the next item is taken once the result is registered
// reset (rst, synchronous, active high) clears the sequencer and result valid
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_offset (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic [gdo_pkg::MONTH_W-1:0]             start_month,
  input  wire logic [gdo_pkg::DAY_W-1:0]               start_day,
  input  wire logic [gdo_pkg::YEAR_W-1:0]              start_year,
  input  wire logic signed [gdo_pkg::OFFSET_BITS-1:0]  day_offset,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [gdo_pkg::MONTH_W-1:0]                  result_month,
  output logic [gdo_pkg::DAY_W-1:0]                    result_day,
  output logic [gdo_pkg::YEAR_W-1:0]                   result_year,
  output logic [gdo_pkg::STATUS_W-1:0]                 clamp_status
);
  import gdo_pkg::*;

  gdo_cmd_t  cmd;
  gdo_stat_t stat;

  gdo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gdo_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .start_month  (start_month),
    .start_day    (start_day),
    .start_year   (start_year),
    .day_offset   (day_offset),
    .result_month (result_month),
    .result_day   (result_day),
    .result_year  (result_year),
    .clamp_status (clamp_status)
  );

endmodule
`default_nettype wire
